>>> hw/rtl/cld_pkg.sv
// ----------------------------------------------------------------------------
// Circular list engine package
// Shared field types, operation and status codes, and the queue entry format.
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic [MODE_W-1:0]          mode_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0]        status_t;

    localparam mode_t MODE_APPEND    = 3'd0;
    localparam mode_t MODE_DEL_FIRST = 3'd1;
    localparam mode_t MODE_DEL_VALUE = 3'd2;
    localparam mode_t MODE_DEL_LAST  = 3'd3;
    localparam mode_t MODE_DISPLAY   = 3'd4;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    typedef struct packed {
        mode_t  mode;
        value_t value;
    } op_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    function automatic logic mode_known(input mode_t m);
        return (m == MODE_APPEND) || (m == MODE_DEL_FIRST) || (m == MODE_DEL_VALUE) ||
               (m == MODE_DEL_LAST) || (m == MODE_DISPLAY);
    endfunction

endpackage

>>> hw/rtl/cld_front.sv
// ----------------------------------------------------------------------------
// Circular list engine front end
// Accepts input transactions, drops unused modes, and forwards operations.
// ----------------------------------------------------------------------------
module cld_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  cld_pkg::mode_t   s_mode,
    input  cld_pkg::value_t  s_value,
    output logic             push_valid,
    input  logic             push_ready,
    output cld_pkg::op_t     push_op
);
    import cld_pkg::*;

    assign s_ready       = push_ready;
    assign push_valid    = s_valid && mode_known(s_mode);
    assign push_op.mode  = s_mode;
    assign push_op.value = s_value;

endmodule

>>> hw/rtl/cld_queue.sv
// ----------------------------------------------------------------------------
// Circular list engine operation queue
// Short FIFO that decouples the front end from the list engine.
// ----------------------------------------------------------------------------
module cld_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  cld_pkg::op_t  push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cld_pkg::op_t  pop_op
);
    import cld_pkg::*;

    op_t               q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_op     = q_mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> hw/rtl/cld_back.sv
// ----------------------------------------------------------------------------
// Circular list engine back end
// Ring-buffer entry memory, operation sequencer and result output register.
// ----------------------------------------------------------------------------
module cld_back #(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  cld_pkg::op_t     q_op,
    output logic             m_valid,
    input  logic             m_ready,
    output cld_pkg::value_t  m_item_value,
    output cld_pkg::status_t m_status,
    output logic             m_last
);
    import cld_pkg::*;

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = PW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_EMIT   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DISP   = 3'd4;

    value_t mem_array [CAPACITY];

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic [PW-1:0] rd_phys_reg, rd_phys_next;
    logic [PW-1:0] phys_prev_reg, phys_prev_next;
    logic          rd_last_reg, rd_last_next;
    value_t        val_reg, val_next;
    value_t        res_value_reg, res_value_next;
    status_t       res_status_reg, res_status_next;
    value_t        rd_data_reg;
    logic          m_valid_reg, m_valid_next;
    value_t        m_item_value_reg;
    status_t       m_status_reg;
    logic          m_last_reg;

    logic          rd_en, wr_en;
    logic [PW-1:0] rd_addr, wr_addr;
    value_t        wr_data;
    logic          out_load, out_last;
    value_t        out_value;
    status_t       out_status;
    logic          can_load, is_empty, is_full, more, scan_issue, disp_issue;

    function automatic logic [PW-1:0] ring_idx(input logic [PW-1:0] base,
                                               input logic [CW-1:0] ofs);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(ofs);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return s[PW-1:0];
    endfunction

    assign can_load   = !m_valid_reg || m_ready;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign more       = (k_reg < count_reg);
    assign scan_issue = more;
    assign disp_issue = more && (!pend_reg || can_load);

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        rd_phys_next    = rd_phys_reg;
        phys_prev_next  = phys_prev_reg;
        rd_last_next    = rd_last_reg;
        val_next        = val_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = phys_prev_reg;
        wr_data         = rd_data_reg;
        q_ready         = 1'b0;
        out_load        = 1'b0;
        out_value       = '0;
        out_status      = ST_OK;
        out_last        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    res_value_next  = '0;
                    res_status_next = ST_EMPTY;
                    state_next      = S_EMIT;
                    case (q_op.mode)
                        MODE_APPEND: begin
                            if (is_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                wr_en           = 1'b1;
                                wr_addr         = ring_idx(head_reg, count_reg);
                                wr_data         = q_op.value;
                                count_next      = count_reg + CW'(1);
                                res_status_next = ST_OK;
                            end
                        end
                        MODE_DEL_FIRST: begin
                            if (!is_empty) begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                head_next  = ring_idx(head_reg, CW'(1));
                                count_next = count_reg - CW'(1);
                                state_next = S_RDWAIT;
                            end
                        end
                        MODE_DEL_LAST: begin
                            if (!is_empty) begin
                                rd_en      = 1'b1;
                                rd_addr    = ring_idx(head_reg, count_reg - CW'(1));
                                count_next = count_reg - CW'(1);
                                state_next = S_RDWAIT;
                            end
                        end
                        MODE_DEL_VALUE: begin
                            if (!is_empty) begin
                                val_next   = q_op.value;
                                k_next     = '0;
                                found_next = 1'b0;
                                pend_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        MODE_DISPLAY: begin
                            if (!is_empty) begin
                                k_next     = '0;
                                pend_next  = 1'b0;
                                state_next = S_DISP;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                res_value_next  = rd_data_reg;
                res_status_next = ST_OK;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                if (can_load) begin
                    out_load   = 1'b1;
                    out_value  = res_value_reg;
                    out_status = res_status_reg;
                    out_last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                // shift every entry after the match one slot toward the head
                if (scan_issue) begin
                    rd_en        = 1'b1;
                    rd_addr      = ring_idx(head_reg, k_reg);
                    rd_phys_next = ring_idx(head_reg, k_reg);
                    k_next       = k_reg + CW'(1);
                end
                pend_next = scan_issue;
                if (pend_reg) begin
                    phys_prev_next = rd_phys_reg;
                    if (found_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = phys_prev_reg;
                        wr_data = rd_data_reg;
                    end else if (rd_data_reg == val_reg) begin
                        found_next = 1'b1;
                    end
                end
                if (!scan_issue && !pend_reg) begin
                    state_next = S_EMIT;
                    if (found_reg) begin
                        count_next      = count_reg - CW'(1);
                        res_value_next  = val_reg;
                        res_status_next = ST_OK;
                    end else begin
                        res_value_next  = '0;
                        res_status_next = ST_NOTFOUND;
                    end
                end
            end
            S_DISP: begin
                if (pend_reg && can_load) begin
                    out_load   = 1'b1;
                    out_value  = rd_data_reg;
                    out_status = ST_OK;
                    out_last   = rd_last_reg;
                    pend_next  = 1'b0;
                    if (rd_last_reg) begin
                        state_next = S_IDLE;
                    end
                end
                if (disp_issue) begin
                    rd_en        = 1'b1;
                    rd_addr      = ring_idx(head_reg, k_reg);
                    rd_last_next = (k_reg == count_reg - CW'(1));
                    k_next       = k_reg + CW'(1);
                    pend_next    = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_phys_reg    <= rd_phys_next;
        phys_prev_reg  <= phys_prev_next;
        rd_last_reg    <= rd_last_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_item_value_reg <= out_value;
            m_status_reg     <= out_status;
            m_last_reg       <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_item_value = m_item_value_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

endmodule

>>> hw/rtl/circular_list_delete_engine_unit.sv
// ----------------------------------------------------------------------------
// Circular list delete engine
// Bounded ordered list of signed 32-bit values with append, deletes and display.
// ----------------------------------------------------------------------------
// The list lives in a ring buffer of CAPACITY entries with one read and one
// write port. Operations queue in a two-entry FIFO behind the input, so up to
// two further transactions are taken while one executes. Append and any
// operation on an empty list go from idle straight to the result state;
// delete first or last passes through a read-wait state first, and delete
// by value reads every entry (one entry read per cycle, closing the gap in
// the same pass). Display presents its entries from the head onward, one
// entry per cycle while the receiver is ready. Unused modes are accepted and
// produce nothing.
module circular_list_delete_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cld_pkg::mode_t   s_mode,
    input  cld_pkg::value_t  s_value,
    output logic             m_valid,
    input  logic             m_ready,
    output cld_pkg::value_t  m_item_value,
    output cld_pkg::status_t m_status,
    output logic             m_last
);
    import cld_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    op_t  push_op, pop_op;

    cld_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_value    (s_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    cld_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    cld_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (pop_valid),
        .q_ready      (pop_ready),
        .q_op         (pop_op),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item_value (m_item_value),
        .m_status     (m_status),
        .m_last       (m_last)
    );

endmodule

>>> hw/rtl/cld_checker.sv
// ----------------------------------------------------------------------------
// Circular list engine port checker
// Watches the top-level ports for handshake and result-channel rules.
// ----------------------------------------------------------------------------
module cld_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input cld_pkg::mode_t   s_mode,
    input cld_pkg::value_t  s_value,
    input logic             m_valid,
    input logic             m_ready,
    input cld_pkg::value_t  m_item_value,
    input cld_pkg::status_t m_status,
    input logic             m_last
);
    import cld_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_mode) && $stable(s_value))
        else $error("input changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item_value) &&
                                $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_last)
        else $error("error status not marked last");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_item_value == '0))
        else $error("error status with nonzero value");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind circular_list_delete_engine_unit cld_checker u_cld_checker (.*);
